FILE: src/qnv_pkg.sv
// ----------------------------------------------------------------------------
// qnv_pkg
// Shared types and character constants for the qualified name validator.
// ----------------------------------------------------------------------------
package qnv_pkg;

	typedef enum logic [2:0] {
		SEC_PREFIX,
		SEC_COLON,
		SEC_NAME,
		SEC_SUFFIX,
		SEC_KEY,
		SEC_VALUE
	} section_t;

	typedef enum logic [3:0] {
		ERR_NONE,
		ERR_EMPTY_PREFIX,
		ERR_PREFIX_CHAR,
		ERR_DOUBLE_ANGLE,
		ERR_NO_SCOPE,
		ERR_EMPTY_NAME,
		ERR_NAME_CHAR,
		ERR_DOUBLE_SQUARE,
		ERR_SUFFIX_CHAR,
		ERR_SUFFIX_AFTER_OPT,
		ERR_MISSING_EQUALS,
		ERR_EMPTY_KEY,
		ERR_KEY_CHAR,
		ERR_EMPTY_VALUE,
		ERR_VALUE_CHAR
	} err_t;

	typedef struct packed {
		logic prefix_ok;
		logic name_ok;
		logic suffix_ok;
		logic key_ok;
		logic value_ok;
	} char_class_t;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;

endpackage

FILE: src/qnv_if.sv
// ----------------------------------------------------------------------------
// qnv_if
// Valid/ready request channels for characters in and check results out.
// ----------------------------------------------------------------------------
interface qnv_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       is_last;

	modport source (output valid, output char_in, output is_last, input ready);
	modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

interface qnv_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] section_tag;
	logic       error_seen;
	logic [3:0] error_kind;
	logic       done_res;
	logic       accepted;

	modport source (output valid, output section_tag, output error_seen,
		output error_kind, output done_res, output accepted, input ready);
	modport sink   (input valid, input section_tag, input error_seen,
		input error_kind, input done_res, input accepted, output ready);
endinterface

FILE: src/qnv_char_class.sv
// ----------------------------------------------------------------------------
// qnv_char_class
// Per-section character set membership for one byte.
// ----------------------------------------------------------------------------
module qnv_char_class (
	input  logic [7:0]                c,
	output qnv_pkg::char_class_t      cls
);

	logic alnum;

	assign alnum = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
		(c >= 8'h30 && c <= 8'h39);

	// prefix: < > ^ _ * + - ( )
	assign cls.prefix_ok = alnum || (c inside {8'h3C, 8'h3E, 8'h5E, 8'h5F, 8'h2A,
		8'h2B, 8'h2D, 8'h28, 8'h29});
	// name: ( ) [ ] { } | ' , . / ^ _ * + - =
	assign cls.name_ok = alnum || (c inside {8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B,
		8'h7D, 8'h7C, 8'h27, 8'h2C, 8'h2E, 8'h2F, 8'h5E, 8'h5F, 8'h2A, 8'h2B,
		8'h2D, 8'h3D});
	// suffix: . : - + ( )
	assign cls.suffix_ok = alnum || (c inside {8'h2E, 8'h3A, 8'h2D, 8'h2B, 8'h28,
		8'h29});
	assign cls.key_ok = alnum || (c == 8'h2D);
	// value: + - / . ^ _
	assign cls.value_ok = alnum || (c inside {8'h2B, 8'h2D, 8'h2F, 8'h2E, 8'h5E,
		8'h5F});

endmodule

FILE: src/qualified_name_validator.sv
// ----------------------------------------------------------------------------
// qualified_name_validator
// Streaming grammar check of prefix::name[@suffix][;key=value{,key=value}].
//
// Usage:
//   item   : one character per request (char_in, is_last marks the final one).
//   result : one result per character: section reached, sticky first error,
//            done_res on the final character and the accept verdict with it.
//   An accepted character's result is registered, valid the next cycle. One
//   character is taken every cycle unless the receiver stalls; the section
//   state and the first-error register update in the same cycle it is taken.
//   The result register decouples the sides: item.ready is high whenever the
//   result register is empty or is being taken, so the stream keeps moving
//   while result.ready stays high. If the receiver stalls, the pending result
//   holds and item.ready drops until it is taken.
//   After the final character the checker returns to the prefix section with
//   no error recorded. Reset (arst_n low) does the same and empties the
//   result register.
// ----------------------------------------------------------------------------
module qualified_name_validator (
	input  logic          clk,
	input  logic          arst_n,
	qnv_char_if.sink      item,
	qnv_res_if.source     result
);

	qnv_pkg::section_t    sec_q, sec_d;
	logic                 part_q, part_d;
	logic [7:0]           prev_q;
	qnv_pkg::err_t        err_q, err_d, kind_c, kind_e;
	qnv_pkg::char_class_t cls;
	logic                 valid_q;
	logic                 accept;
	logic [7:0]           c;

	assign c      = item.char_in;
	assign accept = item.valid && item.ready;

	assign item.ready   = !valid_q || result.ready;
	assign result.valid = valid_q;

	qnv_char_class u_class (
		.c   (c),
		.cls (cls)
	);

	always_comb begin
		sec_d  = sec_q;
		part_d = part_q;
		kind_c = qnv_pkg::ERR_NONE;
		kind_e = qnv_pkg::ERR_NONE;
		unique case (sec_q)
			qnv_pkg::SEC_PREFIX: begin
				if (c == qnv_pkg::CH_COLON) begin
					sec_d = qnv_pkg::SEC_COLON;
				end else begin
					if (!cls.prefix_ok)
						kind_c = qnv_pkg::ERR_PREFIX_CHAR;
					else if ((c == qnv_pkg::CH_LT || c == qnv_pkg::CH_GT) && prev_q == c)
						kind_c = qnv_pkg::ERR_DOUBLE_ANGLE;
					part_d = 1'b1;
				end
			end
			qnv_pkg::SEC_COLON: begin
				if (c == qnv_pkg::CH_COLON) begin
					if (!part_q)
						kind_c = qnv_pkg::ERR_EMPTY_PREFIX;
					sec_d  = qnv_pkg::SEC_NAME;
					part_d = 1'b0;
				end else begin
					kind_c = qnv_pkg::ERR_PREFIX_CHAR;
					sec_d  = qnv_pkg::SEC_PREFIX;
					part_d = 1'b1;
				end
			end
			qnv_pkg::SEC_NAME: begin
				if (c == qnv_pkg::CH_AT || c == qnv_pkg::CH_SEMI) begin
					if (!part_q)
						kind_c = qnv_pkg::ERR_EMPTY_NAME;
					sec_d  = (c == qnv_pkg::CH_AT) ? qnv_pkg::SEC_SUFFIX : qnv_pkg::SEC_KEY;
					part_d = 1'b0;
				end else begin
					if (!cls.name_ok)
						kind_c = qnv_pkg::ERR_NAME_CHAR;
					else if ((c == qnv_pkg::CH_LBRK || c == qnv_pkg::CH_RBRK) && prev_q == c)
						kind_c = qnv_pkg::ERR_DOUBLE_SQUARE;
					part_d = 1'b1;
				end
			end
			qnv_pkg::SEC_SUFFIX: begin
				if (c == qnv_pkg::CH_SEMI) begin
					sec_d  = qnv_pkg::SEC_KEY;
					part_d = 1'b0;
				end else if (!cls.suffix_ok) begin
					kind_c = qnv_pkg::ERR_SUFFIX_CHAR;
				end
			end
			qnv_pkg::SEC_KEY: begin
				if (c == qnv_pkg::CH_EQ) begin
					if (!part_q)
						kind_c = qnv_pkg::ERR_EMPTY_KEY;
					sec_d  = qnv_pkg::SEC_VALUE;
					part_d = 1'b0;
				end else begin
					if (c == qnv_pkg::CH_AT)
						kind_c = qnv_pkg::ERR_SUFFIX_AFTER_OPT;
					else if (!cls.key_ok)
						kind_c = qnv_pkg::ERR_KEY_CHAR;
					part_d = 1'b1;
				end
			end
			qnv_pkg::SEC_VALUE: begin
				if (c == qnv_pkg::CH_COMMA) begin
					if (!part_q)
						kind_c = qnv_pkg::ERR_EMPTY_VALUE;
					sec_d  = qnv_pkg::SEC_KEY;
					part_d = 1'b0;
				end else begin
					if (c == qnv_pkg::CH_AT)
						kind_c = qnv_pkg::ERR_SUFFIX_AFTER_OPT;
					else if (!cls.value_ok)
						kind_c = qnv_pkg::ERR_VALUE_CHAR;
					part_d = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// end-of-name checks on the section reached
		if (item.is_last) begin
			if (sec_d == qnv_pkg::SEC_PREFIX || sec_d == qnv_pkg::SEC_COLON)
				kind_e = qnv_pkg::ERR_NO_SCOPE;
			else if (sec_d == qnv_pkg::SEC_NAME && !part_d)
				kind_e = qnv_pkg::ERR_EMPTY_NAME;
			else if (sec_d == qnv_pkg::SEC_KEY)
				kind_e = qnv_pkg::ERR_MISSING_EQUALS;
			else if (sec_d == qnv_pkg::SEC_VALUE && !part_d)
				kind_e = qnv_pkg::ERR_EMPTY_VALUE;
		end

		if (err_q != qnv_pkg::ERR_NONE)
			err_d = err_q;
		else if (kind_c != qnv_pkg::ERR_NONE)
			err_d = kind_c;
		else
			err_d = kind_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q              <= qnv_pkg::SEC_PREFIX;
			part_q             <= 1'b0;
			prev_q             <= 8'h00;
			err_q              <= qnv_pkg::ERR_NONE;
			valid_q            <= 1'b0;
			result.section_tag <= 3'(qnv_pkg::SEC_PREFIX);
			result.error_seen  <= 1'b0;
			result.error_kind  <= 4'(qnv_pkg::ERR_NONE);
			result.done_res    <= 1'b0;
			result.accepted    <= 1'b0;
		end else begin
			if (accept) begin
				valid_q            <= 1'b1;
				result.section_tag <= 3'(sec_d);
				result.error_seen  <= (err_d != qnv_pkg::ERR_NONE);
				result.error_kind  <= 4'(err_d);
				result.done_res    <= item.is_last;
				result.accepted    <= item.is_last && (err_d == qnv_pkg::ERR_NONE);
				if (item.is_last) begin
					sec_q  <= qnv_pkg::SEC_PREFIX;
					part_q <= 1'b0;
					prev_q <= 8'h00;
					err_q  <= qnv_pkg::ERR_NONE;
				end else begin
					sec_q  <= sec_d;
					part_q <= part_d;
					prev_q <= c;
					err_q  <= err_d;
				end
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/qnv_checker.sv
// ----------------------------------------------------------------------------
// qnv_checker
// Port-level checks for the qualified name validator, bound to the top level.
// ----------------------------------------------------------------------------
module qnv_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] section_tag,
	input logic       error_seen,
	input logic [3:0] error_kind,
	input logic       done_res,
	input logic       accepted
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(section_tag) &&
		$stable(error_kind) && $stable(done_res) && $stable(accepted))
		else $error("stalled result changed");

	// an accepted character's result is valid in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted character produced no result");

	// empty result register never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> done_res && !error_seen &&
		error_kind == qnv_pkg::ERR_NONE)
		else $error("accept with error or before the last character");

	a_err_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_seen == (error_kind != qnv_pkg::ERR_NONE))
		else $error("error flag disagrees with error kind");

endmodule

bind qualified_name_validator qnv_checker u_qnv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item.valid),
	.in_ready    (item.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.section_tag (result.section_tag),
	.error_seen  (result.error_seen),
	.error_kind  (result.error_kind),
	.done_res    (result.done_res),
	.accepted    (result.accepted)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the qualified name validator against a cycle-free grammar tracker.
// Short directed names cover the special endings and bytes. Random names
// follow: mostly well formed, some damaged, some noise. They run under four
// sender and receiver idling phases, with occasional full drains.
// ----------------------------------------------------------------------------
module testbench;

	localparam int    STALL_LIMIT = 4000;
	localparam string PREFIX_SET  = "<>^_*+-()";
	localparam string NAME_SET    = "()[]{}|',./^_*+-=";
	localparam string SUFFIX_SET  = ".:-+()";
	localparam string KEY_SET     = "-";
	localparam string VALUE_SET   = "+-/.^_";
	localparam string DELIMS      = ":@;=,<>[]";

	typedef struct {
		qnv_pkg::section_t sec;
		logic              err_seen;
		qnv_pkg::err_t     kind;
		logic              done;
		logic              ok;
	} verdict_t;

	logic clk;
	logic arst_n;

	qnv_char_if char_ch ();
	qnv_res_if  res_ch ();

	qualified_name_validator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (char_ch),
		.result (res_ch)
	);

	verdict_t          pending_verdicts[$];
	qnv_pkg::section_t cur_sec;
	logic              colon_wait;
	logic              part_filled;
	logic [7:0]        last_char;
	qnv_pkg::err_t     first_err;

	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          fail_count     = 0;
	int          stall_cycles   = 0;
	int          char_count     = 0;
	int          name_count     = 0;
	int          result_count   = 0;
	int          accept_count   = 0;
	logic [15:0] kinds_seen     = '0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------- grammar tracker ----------------
	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
	endfunction

	function automatic logic in_class(input logic [7:0] c, input string extra);
		int i;
		if (is_alnum(c))
			return 1'b1;
		for (i = 0; i < extra.len(); i++)
			if (extra[i] == c)
				return 1'b1;
		return 1'b0;
	endfunction

	task note_error(input qnv_pkg::err_t k);
		if (first_err == qnv_pkg::ERR_NONE)
			first_err = k;
	endtask

	task clear_grammar();
		cur_sec     = qnv_pkg::SEC_PREFIX;
		colon_wait  = 1'b0;
		part_filled = 1'b0;
		last_char   = 8'h00;
		first_err   = qnv_pkg::ERR_NONE;
	endtask

	task prefix_char(input logic [7:0] c);
		if (c == qnv_pkg::CH_COLON) begin
			cur_sec    = qnv_pkg::SEC_COLON;
			colon_wait = 1'b1;
		end else begin
			if (!in_class(c, PREFIX_SET))
				note_error(qnv_pkg::ERR_PREFIX_CHAR);
			else if ((c == qnv_pkg::CH_LT || c == qnv_pkg::CH_GT) && last_char == c)
				note_error(qnv_pkg::ERR_DOUBLE_ANGLE);
			part_filled = 1'b1;
		end
	endtask

	task track_grammar(input logic [7:0] c, input logic last, output verdict_t v);
		case (cur_sec)
			qnv_pkg::SEC_PREFIX: begin
				prefix_char(c);
			end
			qnv_pkg::SEC_COLON: begin
				colon_wait = 1'b0;
				if (c == qnv_pkg::CH_COLON) begin
					if (!part_filled)
						note_error(qnv_pkg::ERR_EMPTY_PREFIX);
					cur_sec     = qnv_pkg::SEC_NAME;
					part_filled = 1'b0;
				end else begin
					note_error(qnv_pkg::ERR_PREFIX_CHAR);
					cur_sec     = qnv_pkg::SEC_PREFIX;
					part_filled = 1'b1;
					prefix_char(c);
				end
			end
			qnv_pkg::SEC_NAME: begin
				if (c == qnv_pkg::CH_AT || c == qnv_pkg::CH_SEMI) begin
					if (!part_filled)
						note_error(qnv_pkg::ERR_EMPTY_NAME);
					cur_sec     = (c == qnv_pkg::CH_AT) ? qnv_pkg::SEC_SUFFIX :
						qnv_pkg::SEC_KEY;
					part_filled = 1'b0;
				end else begin
					if (!in_class(c, NAME_SET))
						note_error(qnv_pkg::ERR_NAME_CHAR);
					else if ((c == qnv_pkg::CH_LBRK || c == qnv_pkg::CH_RBRK) &&
							last_char == c)
						note_error(qnv_pkg::ERR_DOUBLE_SQUARE);
					part_filled = 1'b1;
				end
			end
			qnv_pkg::SEC_SUFFIX: begin
				if (c == qnv_pkg::CH_SEMI) begin
					cur_sec     = qnv_pkg::SEC_KEY;
					part_filled = 1'b0;
				end else if (!in_class(c, SUFFIX_SET)) begin
					note_error(qnv_pkg::ERR_SUFFIX_CHAR);
				end
			end
			qnv_pkg::SEC_KEY: begin
				if (c == qnv_pkg::CH_EQ) begin
					if (!part_filled)
						note_error(qnv_pkg::ERR_EMPTY_KEY);
					cur_sec     = qnv_pkg::SEC_VALUE;
					part_filled = 1'b0;
				end else begin
					if (c == qnv_pkg::CH_AT)
						note_error(qnv_pkg::ERR_SUFFIX_AFTER_OPT);
					else if (!in_class(c, KEY_SET))
						note_error(qnv_pkg::ERR_KEY_CHAR);
					part_filled = 1'b1;
				end
			end
			qnv_pkg::SEC_VALUE: begin
				if (c == qnv_pkg::CH_COMMA) begin
					if (!part_filled)
						note_error(qnv_pkg::ERR_EMPTY_VALUE);
					cur_sec     = qnv_pkg::SEC_KEY;
					part_filled = 1'b0;
				end else begin
					if (c == qnv_pkg::CH_AT)
						note_error(qnv_pkg::ERR_SUFFIX_AFTER_OPT);
					else if (!in_class(c, VALUE_SET))
						note_error(qnv_pkg::ERR_VALUE_CHAR);
					part_filled = 1'b1;
				end
			end
			default: begin
			end
		endcase
		last_char = c;

		if (last) begin
			if (cur_sec == qnv_pkg::SEC_PREFIX || cur_sec == qnv_pkg::SEC_COLON)
				note_error(qnv_pkg::ERR_NO_SCOPE);
			else if (cur_sec == qnv_pkg::SEC_NAME && !part_filled)
				note_error(qnv_pkg::ERR_EMPTY_NAME);
			else if (cur_sec == qnv_pkg::SEC_KEY)
				note_error(qnv_pkg::ERR_MISSING_EQUALS);
			else if (cur_sec == qnv_pkg::SEC_VALUE && !part_filled)
				note_error(qnv_pkg::ERR_EMPTY_VALUE);
		end

		v.sec      = cur_sec;
		v.err_seen = (first_err != qnv_pkg::ERR_NONE);
		v.kind     = first_err;
		v.done     = last;
		v.ok       = last && (first_err == qnv_pkg::ERR_NONE);

		if (last)
			clear_grammar();
	endtask

	// ---------------- driving ----------------
	task log_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch: %s", msg);
	endtask

	task send_char(input logic [7:0] c, input logic last);
		verdict_t v;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			char_ch.valid <= 1'b0;
			@(negedge clk);
		end
		char_ch.valid   <= 1'b1;
		char_ch.char_in <= c;
		char_ch.is_last <= last;
		do @(posedge clk); while (!char_ch.ready);
		track_grammar(c, last, v);
		pending_verdicts.push_back(v);
		char_count++;
		if (last) begin
			name_count++;
			kinds_seen[v.kind] = 1'b1;
		end
	endtask

	task send_text(input string t);
		int i;
		for (i = 0; i < t.len(); i++)
			send_char(t[i], i == t.len() - 1);
	endtask

	task wait_for_results();
		@(negedge clk);
		char_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk)
		res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// ---------------- random names ----------------
	function automatic logic [7:0] class_char(input string set);
		if ($urandom_range(0, 99) < 60) begin
			case ($urandom_range(0, 2))
				0: return 8'(8'h61 + $urandom_range(0, 25));
				1: return 8'(8'h41 + $urandom_range(0, 25));
				default: return 8'(8'h30 + $urandom_range(0, 9));
			endcase
		end
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	function automatic logic [7:0] noise_char();
		if ($urandom_range(0, 1))
			return 8'($urandom_range(0, 255));
		return DELIMS[$urandom_range(0, DELIMS.len() - 1)];
	endfunction

	task automatic add_chars(ref logic [7:0] s[$], input string set, input int lo, input int hi);
		int n;
		n = $urandom_range(lo, hi);
		repeat (n) s.push_back(class_char(set));
	endtask

	task automatic mutate(ref logic [7:0] s[$]);
		int pos;
		pos = $urandom_range(0, s.size() - 1);
		case ($urandom_range(0, 4))
			0: s[pos] = 8'($urandom_range(0, 255));
			1: s[pos] = DELIMS[$urandom_range(0, DELIMS.len() - 1)];
			2: if (s.size() > 1) s.delete(pos);
			3: s.insert(pos, DELIMS[$urandom_range(0, DELIMS.len() - 1)]);
			default: s = s[0:pos];
		endcase
	endtask

	task automatic make_name(ref logic [7:0] s[$]);
		int kind;
		int n;
		int k;
		s = {};
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			n = $urandom_range(1, 6);
			repeat (n) s.push_back(noise_char());
		end else begin
			add_chars(s, PREFIX_SET, 1, 4);
			s.push_back(qnv_pkg::CH_COLON);
			s.push_back(qnv_pkg::CH_COLON);
			add_chars(s, NAME_SET, 1, 4);
			if ($urandom_range(0, 1)) begin
				s.push_back(qnv_pkg::CH_AT);
				add_chars(s, SUFFIX_SET, 0, 3);
			end
			if ($urandom_range(0, 1)) begin
				s.push_back(qnv_pkg::CH_SEMI);
				n = $urandom_range(1, 2);
				for (k = 0; k < n; k++) begin
					if (k != 0)
						s.push_back(qnv_pkg::CH_COMMA);
					add_chars(s, KEY_SET, 1, 3);
					s.push_back(qnv_pkg::CH_EQ);
					add_chars(s, VALUE_SET, 1, 3);
				end
			end
			if (kind >= 62) begin
				n = $urandom_range(1, 2);
				repeat (n) mutate(s);
			end
		end
	endtask

	// ---------------- checking ----------------
	always @(posedge clk) begin : result_check
		verdict_t v;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			result_count++;
			if (pending_verdicts.size() == 0) begin
				log_failure($sformatf("result %0d with no request pending: sec=%0d kind=%0d",
					result_count, res_ch.section_tag, res_ch.error_kind));
			end else begin
				v = pending_verdicts.pop_front();
				if (res_ch.section_tag !== v.sec || res_ch.error_seen !== v.err_seen ||
						res_ch.error_kind !== v.kind || res_ch.done_res !== v.done ||
						res_ch.accepted !== v.ok)
					log_failure($sformatf(
						"result %0d exp sec=%0d seen=%0b kind=%0d done=%0b acc=%0b got %0d %0b %0d %0b %0b",
						result_count, v.sec, v.err_seen, v.kind, v.done, v.ok,
						res_ch.section_tag, res_ch.error_seen, res_ch.error_kind,
						res_ch.done_res, res_ch.accepted));
				if (res_ch.done_res === 1'b1 && res_ch.accepted === 1'b1)
					accept_count++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (char_ch.valid && char_ch.ready) || (res_ch.valid && res_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
		$display("FAIL");
		$finish;
	end

	// ---------------- tests ----------------
	task test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b1);
		send_text("a::b");
		send_text("a:b");
		send_text("::x");
		send_text("a::");
		send_text("a::b:");
		send_text("a::b@@");
		send_text("a::b;k");
		wait_for_results();
	endtask

	task test_random(input int idle_pct, input int stall_pct, input int budget);
		logic [7:0] s[$];
		int start;
		int i;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = char_count;
		while (char_count - start < budget) begin
			make_name(s);
			for (i = 0; i < s.size(); i++)
				send_char(s[i], i == s.size() - 1);
			if ($urandom_range(0, 99) < 4)
				wait_for_results();
		end
		wait_for_results();
	endtask

	initial begin
		arst_n          = 1'b0;
		char_ch.valid   = 1'b0;
		char_ch.char_in = 8'h00;
		char_ch.is_last = 1'b0;
		res_ch.ready    = 1'b0;
		clear_grammar();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(0, 0, 370);
		test_random(54, 0, 370);
		test_random(0, 54, 370);
		test_random(18, 18, 370);

		wait_for_results();
		repeat (10) @(posedge clk);
		if (pending_verdicts.size() != 0)
			log_failure($sformatf("%0d results never arrived", pending_verdicts.size()));

		$display("ran %0d names, %0d characters, %0d accepted, %0d mismatches",
			name_count, char_count, accept_count, fail_count);
		$display("error classes reached (bit per class): %b", kinds_seen);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: files.f
src/qnv_pkg.sv
src/qnv_if.sv
src/qnv_char_class.sv
src/qualified_name_validator.sv
src/qnv_checker.sv
bench/testbench.sv
